// File: hw/rtl/rvalu_pkg.sv
// rvalu_pkg: opcodes, function codes and result type for the RV32IM execute block.
// No dependencies.
package rvalu_pkg;
  localparam logic [6:0] OPC_OP    = 7'h33;
  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [31:0] PC_STEP  = 32'd4;

  typedef struct packed {
    logic        illegal;
    logic [31:0] next_pc;
    logic [31:0] write_value;
    logic [4:0]  dest_register;
    logic        wrote_register;
  } result_t;
endpackage

// File: hw/rtl/rv32im_alu_execute_top.sv
// rv32im_alu_execute_top: RV32IM OP / OP-IMM execute with register file memory.
// Depends on rvalu_pkg.
// Flow: ALU ops pass through operand read (S_RD) and execute (S_EX) to the result
// (S_OUT); multiply adds the product register (S_MUL); divide and remainder add 32
// radix-2 iterations (S_DIV), one quotient bit per cycle, plus fixup (S_DFIN). One
// instruction at a time; the next can be accepted in the cycle after the result
// transaction.
// Reset: synchronous; clears program counter to 0 and runs a clearing pass over all
// 32 register file entries before the first instruction is accepted.
module rv32im_alu_execute_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,       // start_pc
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,         // [31:0] instruction
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata          // [0] wrote_register, [5:1] dest_register,
                                       // [37:6] write_value, [69:38] next_pc,
                                       // [70] illegal, [71] zero fill
);
  import rvalu_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;  // memory read issued
  localparam logic [3:0] S_EX   = 4'd3;  // operands valid
  localparam logic [3:0] S_MUL  = 4'd4;  // product registered
  localparam logic [3:0] S_DIV  = 4'd5;  // divider iterating
  localparam logic [3:0] S_DFIN = 4'd6;  // divider fixup
  localparam logic [3:0] S_OUT  = 4'd7;  // result waiting

  logic [3:0]  state;
  logic [31:0] pc;
  logic [31:0] instr;
  logic [5:0]  clr_cnt;

  // register file: two read copies written together
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [31:0] rd_a, rd_b;
  logic        we;
  logic [4:0]  waddr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      rf_a[waddr] <= wdata;
      rf_b[waddr] <= wdata;
    end
    rd_a <= rf_a[instr[19:15]];
    rd_b <= rf_b[instr[24:20]];
  end

  // decode
  logic [6:0] opc, f7;
  logic [2:0] f3;
  logic [4:0] rd;
  assign opc = instr[6:0];
  assign f3  = instr[14:12];
  assign f7  = instr[31:25];
  assign rd  = instr[11:7];

  logic [31:0] a, b, imm;
  assign a   = (instr[19:15] == 5'd0) ? 32'd0 : rd_a;
  assign imm = {{20{instr[31]}}, instr[31:20]};
  assign b   = (opc == OPC_OP) ? ((instr[24:20] == 5'd0) ? 32'd0 : rd_b) : imm;

  logic        is_op, is_mul, is_div, ok;
  logic [4:0]  sh;
  logic [31:0] alu;
  assign is_op  = (opc == OPC_OP);
  assign is_mul = is_op && (f7 == F7_MULDIV) && !f3[2];
  assign is_div = is_op && (f7 == F7_MULDIV) && f3[2];
  assign sh     = b[4:0];

  always_comb begin
    ok  = 1'b1;
    alu = 32'd0;
    if (is_op) begin
      if (!(f7 == F7_BASE || f7 == F7_ALT || f7 == F7_MULDIV)) ok = 1'b0;
      if (f7 == F7_ALT && !(f3 == 3'd0 || f3 == 3'd5)) ok = 1'b0;
    end else if (opc == OPC_OPIMM) begin
      if (f3 == 3'd1 && f7 != F7_BASE) ok = 1'b0;
      if (f3 == 3'd5 && !(f7 == F7_BASE || f7 == F7_ALT)) ok = 1'b0;
    end else begin
      ok = 1'b0;
    end
    case (f3)
      3'd0: alu = (is_op && f7 == F7_ALT) ? a - b : a + b;
      3'd1: alu = a << sh;
      3'd2: alu = {31'd0, $signed(a) < $signed(b)};
      3'd3: alu = {31'd0, a < b};
      3'd4: alu = a ^ b;
      3'd5: alu = f7[5] ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: alu = a | b;
      default: alu = a & b;
    endcase
  end

  // multiplier: 33x33 signed, combinational, product registered
  logic        mul_hi;
  logic [63:0] prod;
  logic signed [32:0] ma, mb;
  assign ma = {(f3 == 3'd1 || f3 == 3'd2) & a[31], a};
  assign mb = {(f3 == 3'd1) & b[31], b};

  // radix-2 restoring divider on magnitudes
  logic [31:0] dq, dr, dd;      // quotient/dividend shift, remainder, divisor
  logic [5:0]  dcnt;
  logic        neg_q, neg_r, dzero, want_rem;
  logic [32:0] trial;
  logic [31:0] orig_a;
  assign trial = {dr, dq[31]} - {1'b0, dd};

  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      pc      <= 32'd0;
      clr_cnt <= 6'd0;
      we      <= 1'b0;
    end else begin
      we <= 1'b0;
      if (cfg_we) pc <= cfg_wdata;
      case (state)
        S_CLR: begin
          we      <= 1'b1;
          waddr   <= clr_cnt[4:0];
          wdata   <= 32'd0;
          clr_cnt <= clr_cnt + 6'd1;
          if (clr_cnt == 6'd31) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid) begin
          instr <= s_tdata;
          state <= S_RD;
        end
        S_RD: state <= S_EX;
        S_EX: begin
          if (!ok) begin
            res <= '{illegal: 1'b1, next_pc: pc, write_value: 32'd0,
                     dest_register: 5'd0, wrote_register: 1'b0};
            state <= S_OUT;
          end else if (is_mul) begin
            prod   <= 64'(ma * mb);
            mul_hi <= (f3 != 3'd0);
            state  <= S_MUL;
          end else if (is_div) begin
            neg_q    <= !f3[0] && (a[31] ^ b[31]);
            neg_r    <= !f3[0] && a[31];
            dzero    <= (b == 32'd0);
            want_rem <= f3[1];
            orig_a   <= a;
            dq       <= (!f3[0] && a[31]) ? -a : a;
            dd       <= (!f3[0] && b[31]) ? -b : b;
            dr       <= 32'd0;
            dcnt     <= 6'd0;
            state    <= S_DIV;
          end else begin
            wdata <= alu;
            state <= S_OUT;
          end
          if (ok && !is_mul && !is_div) begin
            we  <= (rd != 5'd0);
            waddr <= rd;
            pc  <= pc + PC_STEP;
            res <= '{illegal: 1'b0, next_pc: pc + PC_STEP, write_value: alu,
                     dest_register: rd, wrote_register: rd != 5'd0};
          end
        end
        S_MUL: begin
          wdata <= mul_hi ? prod[63:32] : prod[31:0];
          we    <= (rd != 5'd0);
          waddr <= rd;
          pc    <= pc + PC_STEP;
          res   <= '{illegal: 1'b0, next_pc: pc + PC_STEP,
                     write_value: mul_hi ? prod[63:32] : prod[31:0],
                     dest_register: rd, wrote_register: rd != 5'd0};
          state <= S_OUT;
        end
        S_DIV: begin
          dr   <= trial[32] ? {dr[30:0], dq[31]} : trial[31:0];
          dq   <= {dq[30:0], !trial[32]};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd31) state <= S_DFIN;
        end
        S_DFIN: begin
          // zero divisor: quotient all ones, remainder the dividend
          logic [31:0] v;
          v = dzero ? (want_rem ? orig_a : 32'hFFFF_FFFF)
                    : (want_rem ? (neg_r ? -dr : dr) : (neg_q ? -dq : dq));
          wdata <= v;
          we    <= (rd != 5'd0);
          waddr <= rd;
          pc    <= pc + PC_STEP;
          res   <= '{illegal: 1'b0, next_pc: pc + PC_STEP, write_value: v,
                     dest_register: rd, wrote_register: rd != 5'd0};
          state <= S_OUT;
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {1'b0, res.illegal, res.next_pc, res.write_value,
                     res.dest_register, res.wrote_register};
endmodule

// File: dv/testbench.sv
// Testbench for rv32im_alu_execute_top: streams RV32 OP / OP-IMM and illegal words,
// predicts each result with a local register file and PC model. Depends on rvalu_pkg.
`timescale 1ns / 100ps

module testbench;
  import rvalu_pkg::*;

  localparam int IDLE_WAIT = 80;       // covers the longest divide plus margin
  localparam int STALL_LIMIT = 20000;  // cycles with no transaction at all
  localparam int LONG_HOLD = 300;      // receiver hold-off for the backpressure test

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] instruction
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [0] wrote_register, [5:1] dest_register, [37:6] write_value,
                          // [69:38] next_pc, [70] illegal

  rv32im_alu_execute_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow architectural state for prediction.
  logic [31:0] shadow_regs [32];
  logic [31:0] shadow_pc;
  result_t     pending_results [$];

  int  error_count = 0;
  bit  sender_idles = 1;
  bit  receiver_idles = 1;
  bit  hold_receiver = 0;
  int  hold_cycles = 0;
  int  long_hold_req = 0;   // bumped by the test, followed by the receiver
  int  long_hold_seen = 0;
  int  quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sra32(logic [31:0] v, logic [4:0] sh);
    return $unsigned($signed(v) >>> sh);
  endfunction

  // Executes one instruction word against the shadow state.
  function automatic result_t execute_word(logic [31:0] word);
    result_t     r;
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2, sh;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, imm, res;
    logic signed [63:0] prod;
    bit ok;
    opc = word[6:0];
    rd = word[11:7];
    f3 = word[14:12];
    rs1 = word[19:15];
    rs2 = word[24:20];
    f7 = word[31:25];
    a = shadow_regs[rs1];
    b = shadow_regs[rs2];
    imm = {{20{word[31]}}, word[31:20]};
    res = '0;
    ok = 1;
    if (opc == OPC_OP) begin
      sh = b[4:0];
      if (f7 == F7_BASE) begin
        case (f3)
          3'd0: res = a + b;
          3'd1: res = a << sh;
          3'd2: res = {31'd0, $signed(a) < $signed(b)};
          3'd3: res = {31'd0, a < b};
          3'd4: res = a ^ b;
          3'd5: res = a >> sh;
          3'd6: res = a | b;
          default: res = a & b;
        endcase
      end else if (f7 == F7_ALT) begin
        if (f3 == 3'd0) res = a - b;
        else if (f3 == 3'd5) res = sra32(a, sh);
        else ok = 0;
      end else if (f7 == F7_MULDIV) begin
        case (f3)
          3'd0: res = a * b;
          3'd1: begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            res = prod[63:32];
          end
          3'd2: begin
            prod = $signed({{32{a[31]}}, a}) * $signed({32'd0, b});
            res = prod[63:32];
          end
          3'd3: res = ({32'd0, a} * {32'd0, b}) >> 32;
          3'd4: begin
            if (b == 0) res = '1;
            else if (a == 32'h8000_0000 && b == '1) res = a;
            else res = $signed(a) / $signed(b);
          end
          3'd5: res = (b == 0) ? '1 : a / b;
          3'd6: begin
            if (b == 0) res = a;
            else if (a == 32'h8000_0000 && b == '1) res = '0;
            else res = $signed(a) % $signed(b);
          end
          default: res = (b == 0) ? a : a % b;
        endcase
      end else ok = 0;
    end else if (opc == OPC_OPIMM) begin
      sh = word[24:20];
      case (f3)
        3'd0: res = a + imm;
        3'd1: if (f7 == F7_BASE) res = a << sh; else ok = 0;
        3'd2: res = {31'd0, $signed(a) < $signed(imm)};
        3'd3: res = {31'd0, a < imm};
        3'd4: res = a ^ imm;
        3'd5: begin
          if (f7 == F7_BASE) res = a >> sh;
          else if (f7 == F7_ALT) res = sra32(a, sh);
          else ok = 0;
        end
        3'd6: res = a | imm;
        default: res = a & imm;
      endcase
    end else ok = 0;

    r = '0;
    if (!ok) begin
      r.next_pc = shadow_pc;
      r.illegal = 1'b1;
      return r;
    end
    if (rd != 0) shadow_regs[rd] = res;
    shadow_pc = shadow_pc + PC_STEP;
    r.wrote_register = (rd != 0);
    r.dest_register = rd;
    r.write_value = res;
    r.next_pc = shadow_pc;
    return r;
  endfunction

  // Sends one instruction; predicts its result at the accepting edge.
  // tvalid stays up after the transaction until the next word or an idle gap.
  task automatic send_word(logic [31:0] word);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(execute_word(word));
    @(negedge clk);
  endtask

  // Drains all expected results, then lets the block settle before a config write.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_pc = value;
  endtask

  function automatic logic [31:0] r_type(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] i_type(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd);
    return {imm, rs1, f3, rd, OPC_OPIMM};
  endfunction

  // Loads a register with an arbitrary 32-bit value via addi/slli/or/ori.
  task automatic load_reg(logic [4:0] rd, logic [31:0] value);
    send_word(i_type(value[31:20], 5'd0, 3'd0, rd));
    send_word(i_type(12'd20, rd, 3'd1, rd));
    send_word(i_type({1'b0, value[19:9]}, 5'd0, 3'd0, 5'd31));
    send_word(i_type(12'd9, 5'd31, 3'd1, 5'd31));
    send_word(r_type(F7_BASE, 5'd31, rd, 3'd6, rd));
    send_word(i_type({3'b0, value[8:0]}, rd, 3'd6, rd));
  endtask

  // Directed: every function, extremes, divide by zero, overflow, x0, illegal words.
  task automatic test_directed;
    int f;
    load_reg(5'd1, 32'h8000_0000);
    load_reg(5'd2, 32'hFFFF_FFFF);
    send_word(r_type(F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd3));  // overflow div
    send_word(r_type(F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd4));  // overflow rem
    send_word(r_type(F7_MULDIV, 5'd0, 5'd1, 3'd5, 5'd5));  // divu by zero
    send_word(r_type(F7_MULDIV, 5'd0, 5'd1, 3'd7, 5'd6));  // remu by zero
    for (f = 0; f < 8; f++) begin
      send_word(r_type(F7_BASE, 5'd2, 5'd1, f[2:0], 5'd7));
      send_word(r_type(F7_MULDIV, 5'd2, 5'd1, f[2:0], 5'd8));
      send_word(i_type(12'hFFF, 5'd1, f[2:0], 5'd9));
    end
    send_word(r_type(F7_ALT, 5'd2, 5'd1, 3'd0, 5'd10));
    send_word(r_type(F7_ALT, 5'd2, 5'd1, 3'd5, 5'd11));  // shift by rs2 low bits
    send_word(i_type({F7_ALT, 5'd31}, 5'd1, 3'd5, 5'd12));
    send_word(r_type(F7_ALT, 5'd2, 5'd1, 3'd1, 5'd13));  // illegal alt funct3
    send_word(r_type(7'h7F, 5'd2, 5'd1, 3'd0, 5'd13));   // illegal funct7
    send_word(i_type({F7_ALT, 5'd3}, 5'd1, 3'd1, 5'd13)); // illegal slli top
    send_word(r_type(F7_BASE, 5'd2, 5'd1, 3'd0, 5'd0));  // x0 destination
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int pick;
    logic [6:0] f7s [3];
    f7s[0] = F7_BASE;
    f7s[1] = F7_ALT;
    f7s[2] = F7_MULDIV;
    w = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w[6:0] = OPC_OP;
      w[31:25] = f7s[$urandom_range(0, 2)];
    end else if (pick < 85) begin
      w[6:0] = OPC_OPIMM;
      if (w[13:12] == 2'b01 && $urandom_range(0, 3) != 0)
        w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
    end else if (pick < 92) begin
      w[6:0] = OPC_OP;  // mostly bad funct7
    end
    return w;
  endfunction

  task automatic test_random(int count);
    repeat (count) send_word(random_word());
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up.
  task automatic test_backpressure;
    long_hold_req = long_hold_req + 1;
    test_random(12);
  endtask

  task automatic test_config;
    write_start_pc(32'hFFFF_FFF8);  // PC wraps through zero
    test_random(20);
    write_start_pc(32'h0000_0000);
    test_random(20);
    write_start_pc($urandom());
    test_random(20);
  endtask

  // Receiver side: random stalls and the long hold-off.
  always @(negedge clk) begin
    int n;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_req != long_hold_seen) begin
      long_hold_seen <= long_hold_req;
      hold_receiver <= 1;
      hold_cycles <= LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_receiver) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles <= 1) hold_receiver <= 0;
    end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      hold_receiver <= (n > 1);
      hold_cycles <= n - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[70:0];
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.wrote_register !== want.wrote_register) begin
          $error("wrote_register exp %0d got %0d", want.wrote_register, got.wrote_register);
          error_count++;
        end
        if (got.dest_register !== want.dest_register) begin
          $error("dest_register exp %0d got %0d", want.dest_register, got.dest_register);
          error_count++;
        end
        if (got.write_value !== want.write_value) begin
          $error("write_value exp %h got %h", want.write_value, got.write_value);
          error_count++;
        end
        if (got.next_pc !== want.next_pc) begin
          $error("next_pc exp %h got %h", want.next_pc, got.next_pc);
          error_count++;
        end
        if (got.illegal !== want.illegal) begin
          $error("illegal exp %0d got %0d", want.illegal, got.illegal);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < 32; i++) shadow_regs[i] = '0;
    shadow_pc = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_config();
    test_backpressure();
    test_random(1300);
    // Final stretch without idling.
    sender_idles = 0;
    receiver_idles = 0;
    test_random(100);

    drain();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
